/* src/kvl_pkg.sv */
// Shared types, sizes and codes for the key-value lookup table.
package kvl_pkg;

	localparam int ENTRIES     = 32;
	localparam int KEY_BYTES   = 8;
	localparam int VALUE_BYTES = 8;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int KEY_W = 8 * KEY_BYTES;
	localparam int VAL_W = 8 * VALUE_BYTES;

	localparam logic [1:0] FUNC_PUT = 2'd0;
	localparam logic [1:0] FUNC_GET = 2'd1;

	localparam logic KIND_PUT = 1'b0;
	localparam logic KIND_GET = 1'b1;

	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_MISS = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] key;
		logic [63:0] value;
	} kvl_req_t;

	typedef struct packed {
		logic        reply_kind;
		logic        status;
		logic [63:0] reply_key;
		logic [63:0] reply_value;
	} kvl_rsp_t;

	typedef struct packed {
		logic [IDX_W-1:0] rd_addr;
		logic             key_we;
		logic             val_we;
		logic [IDX_W-1:0] wr_addr;
		logic [KEY_W-1:0] wr_key;
		logic [VAL_W-1:0] wr_value;
	} kvl_ram_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} kvl_state_t;

endpackage

/* src/key_value_lookup_table.sv */
// Top level of the key-value lookup table: key and value memories plus the request sequencer.
// Done strobes once the scan ends: a get or put that hits entry i ends the scan at that entry,
// and a miss ends it after the last entry. The scan reads one key memory entry per cycle
// through its single read port; busy stays high until it ends, so a new request waits for it.
// Unknown requests are dropped with no reply.
// Reset clears all valid bits at once; no clearing pass. Results cannot be stalled.
module key_value_lookup_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kvl_pkg::kvl_req_t req,
	output logic              done,
	output kvl_pkg::kvl_rsp_t rsp
);
	import kvl_pkg::*;

	kvl_ram_ctl_t     ctl;
	logic [KEY_W-1:0] key_rd;
	logic [VAL_W-1:0] val_rd;

	kvl_ram #(
		.WIDTH(KEY_W),
		.DEPTH(ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (ctl.key_we),
		.waddr(ctl.wr_addr),
		.wdata(ctl.wr_key),
		.raddr(ctl.rd_addr),
		.rdata(key_rd)
	);

	kvl_ram #(
		.WIDTH(VAL_W),
		.DEPTH(ENTRIES)
	) u_val_ram (
		.clk  (clk),
		.we   (ctl.val_we),
		.waddr(ctl.wr_addr),
		.wdata(ctl.wr_value),
		.raddr(ctl.rd_addr),
		.rdata(val_rd)
	);

	kvl_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.key_rd(key_rd),
		.val_rd(val_rd),
		.ctl   (ctl),
		.done  (done),
		.rsp   (rsp)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("reply beat without a request in flight");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("reply beat while still scanning");

	a_unknown_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.func != FUNC_PUT && req.func != FUNC_GET) |=> !done && !busy)
		else $error("unknown request produced activity");

	a_put_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.reply_kind == KIND_PUT) |->
			(rsp.status == STATUS_OK && rsp.reply_key == 64'd0 && rsp.reply_value == 64'd0))
		else $error("malformed put reply");

endmodule

/* src/kvl_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
module kvl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* src/kvl_scan.sv */
// Request sequencer: valid bits, key scan, free-slot search, write-back and reply register.
module kvl_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  kvl_pkg::kvl_req_t     req,
	input  logic [kvl_pkg::KEY_W-1:0] key_rd,
	input  logic [kvl_pkg::VAL_W-1:0] val_rd,
	output kvl_pkg::kvl_ram_ctl_t ctl,
	output logic                  done,
	output kvl_pkg::kvl_rsp_t     rsp
);
	import kvl_pkg::*;

	kvl_state_t       state_q;
	logic             is_get_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [IDX_W-1:0] idx_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [ENTRIES-1:0] valid_q;
	logic             done_q;
	kvl_rsp_t         rsp_q;

	logic             accept;
	logic             known;
	logic             hit;
	logic             last;
	logic             finish;
	logic             ins_ok;
	logic [IDX_W-1:0] ins_idx;

	always_comb begin
		accept  = start && (state_q == ST_IDLE);
		known   = (req.func == FUNC_PUT) || (req.func == FUNC_GET);
		hit     = valid_q[idx_q] && (key_rd == key_q);
		last    = idx_q == IDX_W'(ENTRIES - 1);
		finish  = (state_q == ST_SCAN) && (hit || last);
		ins_ok  = free_found_q || !valid_q[idx_q];
		ins_idx = free_found_q ? free_idx_q : idx_q;

		ctl.rd_addr  = (state_q == ST_SCAN) ? idx_q + IDX_W'(1) : '0;
		ctl.wr_addr  = hit ? idx_q : ins_idx;
		ctl.val_we   = finish && !is_get_q && (hit || ins_ok);
		ctl.key_we   = finish && !is_get_q && !hit && ins_ok;
		ctl.wr_key   = key_q;
		ctl.wr_value = val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			free_found_q <= 1'b0;
			valid_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= finish;
			case (state_q)
				ST_IDLE: begin
					if (accept && known) begin
						state_q      <= ST_SCAN;
						idx_q        <= '0;
						free_found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (ctl.key_we) begin
							valid_q[ins_idx] <= 1'b1;
						end
					end else begin
						idx_q <= idx_q + IDX_W'(1);
						if (!free_found_q && !valid_q[idx_q]) begin
							free_found_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_get_q <= req.func == FUNC_GET;
			key_q    <= req.key[KEY_W-1:0];
			val_q    <= req.value[VAL_W-1:0];
		end
		if (state_q == ST_SCAN && !finish && !free_found_q && !valid_q[idx_q]) begin
			free_idx_q <= idx_q;
		end
		if (finish) begin
			rsp_q.reply_kind  <= is_get_q ? KIND_GET : KIND_PUT;
			rsp_q.status      <= (is_get_q && !hit) ? STATUS_MISS : STATUS_OK;
			rsp_q.reply_key   <= is_get_q ? 64'(key_q) : 64'd0;
			rsp_q.reply_value <= (is_get_q && hit) ? 64'(val_rd) : 64'd0;
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
